### design/tmvm_pkg.sv
// ----------------------------------------------------------------------------
// tmvm_pkg
// Shared constants, codes and control structs of the triangular
// matrix-vector multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package tmvm_pkg;

	// defaults for the top-level parameters
	localparam int DEF_MAX_N     = 16;
	localparam int DEF_FRAC_BITS = 16;

	// field widths
	localparam int KIND_W  = 2;
	localparam int ROW_W   = 4;
	localparam int VALUE_W = 32;
	localparam int IDX_W   = 4;
	localparam int SIZE_W  = 5;
	localparam int CFG_W   = 5;
	localparam int REGI_W  = 2;

	// packed stream widths, rounded up to whole bytes
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	// input item kinds
	localparam logic [KIND_W-1:0] KIND_MAT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VEC  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMP = 2'd2;

	// configuration register indexes
	localparam logic [REGI_W-1:0] REG_LOWER = 2'd0;
	localparam logic [REGI_W-1:0] REG_TRANS = 2'd1;
	localparam logic [REGI_W-1:0] REG_UNIT  = 2'd2;
	localparam logic [REGI_W-1:0] REG_SIZE  = 2'd3;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

	// controller -> datapath commands
	typedef struct packed {
		logic mac_valid;
		logic mac_first;
		logic mac_last;
		logic mac_inside;
		logic mac_unit;
		logic emit_valid;
		logic emit_last;
		logic store_mat;
		logic store_vec;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic mac_busy;
		logic rd_pend;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

### design/triangular_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// triangular_matrix_vector_multiply
// Fixed-point triangular matrix-vector multiply, x := op(A) * x.
// ----------------------------------------------------------------------------
// Matrix and vector elements are loaded one transfer per cycle (tuser selects
// matrix, vector or compute). A compute transfer walks all n*n (i,j) pairs of
// op(A) through a single 33x32 multiplier, one pair per cycle, masking pairs
// outside the selected triangle; the diagonal is taken as one when unit
// diagonal is set. Sums are exact, then shifted right by FRAC_BITS (floor)
// and clipped to 32 bits with the saturated flag. A compute occupies the
// block for the multiply pass over all pairs, a drain of the MAC pipeline,
// then per result a result-buffer read, the output register and the
// handshake (longer under output back-pressure). Results come out in index
// order, tlast on the final one, and are written back to the vector store
// as they go. Loads are not accepted during a compute. Configuration may
// only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module triangular_matrix_vector_multiply #(
	parameter int MAX_N     = tmvm_pkg::DEF_MAX_N,
	parameter int FRAC_BITS = tmvm_pkg::DEF_FRAC_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [tmvm_pkg::IN_DATA_W-1:0]    s_tdata,   // row[3:0], col[7:4], value[39:8]
	input  wire logic [tmvm_pkg::KIND_W-1:0]       s_tuser,   // kind[1:0]
	// result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [tmvm_pkg::OUT_DATA_W-1:0]        m_tdata,   // index[3:0], result[35:4]
	output logic [0:0]                             m_tuser,   // saturated[0]
	output logic                                   m_tlast,
	// configuration writes
	input  wire logic                              cfg_we,
	input  wire logic [tmvm_pkg::REGI_W-1:0]       cfg_index,
	input  wire logic [tmvm_pkg::CFG_W-1:0]        cfg_data
);

	// index widths follow the store depth
	localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
	localparam int MW = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;

	localparam int VW = tmvm_pkg::VALUE_W;
	localparam int RW = tmvm_pkg::ROW_W;

	tmvm_pkg::cmd_t     cmd;
	tmvm_pkg::status_t  st;

	logic [RW-1:0]                  in_row, in_col;
	logic [VW-1:0]                  in_value;
	logic [IW-1:0]                  mac_row, vec_addr, emit_idx;
	logic [MW-1:0]                  mat_addr;
	logic [tmvm_pkg::IDX_W-1:0]     out_index;
	logic [VW-1:0]                  out_result;
	logic                           out_sat;

	// unpack the input transfer
	assign in_row   = s_tdata[RW-1:0];
	assign in_col   = s_tdata[2*RW-1:RW];
	assign in_value = s_tdata[2*RW+VW-1:2*RW];

	tmvm_ctrl #(
		.MAX_N (MAX_N),
		.IW    (IW),
		.MW    (MW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.kind      (s_tuser),
		.row       (in_row),
		.col       (in_col),
		.cmd       (cmd),
		.mac_row   (mac_row),
		.mat_addr  (mat_addr),
		.vec_addr  (vec_addr),
		.emit_idx  (emit_idx),
		.st        (st)
	);

	tmvm_dp #(
		.MAX_N     (MAX_N),
		.FRAC_BITS (FRAC_BITS),
		.IW        (IW),
		.MW        (MW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mac_row    (mac_row),
		.mat_addr   (mat_addr),
		.vec_addr   (vec_addr),
		.emit_idx   (emit_idx),
		.row        (in_row),
		.col        (in_col),
		.value      (in_value),
		.st         (st),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_index  (out_index),
		.out_result (out_result),
		.out_sat    (out_sat),
		.out_last   (m_tlast)
	);

	// pack the result transfer, zero fill to whole bytes
	assign m_tdata = {{(tmvm_pkg::OUT_DATA_W - tmvm_pkg::IDX_W - VW){1'b0}},
	                  out_result, out_index};
	assign m_tuser = out_sat;

endmodule

`default_nettype wire

### design/tmvm_ctrl.sv
// ----------------------------------------------------------------------------
// tmvm_ctrl
// Configuration registers and the sequencer that walks the (i,j) loop of a
// compute and then the result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tmvm_ctrl #(
	parameter int MAX_N = tmvm_pkg::DEF_MAX_N,
	parameter int IW    = 4,
	parameter int MW    = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [tmvm_pkg::REGI_W-1:0]  cfg_index,
	input  wire logic [tmvm_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [tmvm_pkg::KIND_W-1:0]  kind,
	input  wire logic [tmvm_pkg::ROW_W-1:0]   row,
	input  wire logic [tmvm_pkg::ROW_W-1:0]   col,
	output tmvm_pkg::cmd_t                    cmd,
	output logic [IW-1:0]                     mac_row,
	output logic [MW-1:0]                     mat_addr,
	output logic [IW-1:0]                     vec_addr,
	output logic [IW-1:0]                     emit_idx,
	input  wire tmvm_pkg::status_t            st
);

	localparam int NMAX = (MAX_N < 16) ? MAX_N : 16;
	localparam int RW   = tmvm_pkg::ROW_W + 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_FLUSH,
		ST_EMIT,
		ST_DRAIN
	} state_t;

	state_t                       state_q;
	logic                         lower_q, trans_q, unit_q;
	logic [tmvm_pkg::SIZE_W-1:0]  size_q;
	logic [IW-1:0]                i_q, j_q, k_q;
	logic                         mac_valid_q, mac_first_q, mac_last_q;
	logic                         mac_inside_q, mac_unit_q;
	logic                         emit_valid_q, emit_last_q;
	logic [IW-1:0]                mac_row_q, vec_addr_q, emit_idx_q;
	logic [MW-1:0]                mat_addr_q;

	logic [tmvm_pkg::SIZE_W-1:0]  n_eff, nm1;
	logic [IW-1:0]                last_idx, r_idx, c_idx;
	logic                         accept, row_ok, col_ok, in_tri, on_diag;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= 1'b0;
			trans_q <= 1'b0;
			unit_q  <= 1'b0;
			size_q  <= tmvm_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tmvm_pkg::REG_LOWER: lower_q <= cfg_data[0];
				tmvm_pkg::REG_TRANS: trans_q <= cfg_data[0];
				tmvm_pkg::REG_UNIT:  unit_q  <= cfg_data[0];
				tmvm_pkg::REG_SIZE:  size_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_eff    = (size_q > tmvm_pkg::SIZE_W'(NMAX)) ? tmvm_pkg::SIZE_W'(NMAX) : size_q;
	assign nm1      = n_eff - 1'b1;
	assign last_idx = IW'(nm1);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign row_ok   = RW'(row) < RW'(MAX_N);
	assign col_ok   = RW'(col) < RW'(MAX_N);

	// element (i,j) of op(A) lives at A[r][c]
	assign r_idx   = trans_q ? j_q : i_q;
	assign c_idx   = trans_q ? i_q : j_q;
	assign in_tri  = lower_q ? (r_idx >= c_idx) : (r_idx <= c_idx);
	assign on_diag = (i_q == j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			mac_valid_q  <= 1'b0;
			mac_first_q  <= 1'b0;
			mac_last_q   <= 1'b0;
			mac_inside_q <= 1'b0;
			mac_unit_q   <= 1'b0;
			mac_row_q    <= '0;
			mat_addr_q   <= '0;
			vec_addr_q   <= '0;
			emit_valid_q <= 1'b0;
			emit_last_q  <= 1'b0;
			emit_idx_q   <= '0;
		end else begin
			mac_valid_q  <= 1'b0;
			emit_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && kind == tmvm_pkg::KIND_COMP && n_eff != '0) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					mac_valid_q  <= 1'b1;
					mac_first_q  <= (j_q == '0);
					mac_last_q   <= (j_q == last_idx);
					mac_inside_q <= in_tri;
					mac_unit_q   <= unit_q && on_diag;
					mac_row_q    <= i_q;
					mat_addr_q   <= MW'(r_idx) * MW'(MAX_N) + MW'(c_idx);
					vec_addr_q   <= j_q;
					if (j_q == last_idx) begin
						j_q <= '0;
						if (i_q == last_idx)
							state_q <= ST_FLUSH;
						else
							i_q <= IW'(i_q + 1'b1);
					end else begin
						j_q <= IW'(j_q + 1'b1);
					end
				end
				ST_FLUSH: begin
					if (!mac_valid_q && !st.mac_busy) begin
						k_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!emit_valid_q && !st.rd_pend && st.out_free) begin
						emit_valid_q <= 1'b1;
						emit_idx_q   <= k_q;
						emit_last_q  <= (k_q == last_idx);
						if (k_q == last_idx)
							state_q <= ST_DRAIN;
						else
							k_q <= IW'(k_q + 1'b1);
					end
				end
				ST_DRAIN: begin
					if (!emit_valid_q && !st.rd_pend)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.mac_valid  = mac_valid_q;
		cmd.mac_first  = mac_first_q;
		cmd.mac_last   = mac_last_q;
		cmd.mac_inside = mac_inside_q;
		cmd.mac_unit   = mac_unit_q;
		cmd.emit_valid = emit_valid_q;
		cmd.emit_last  = emit_last_q;
		cmd.store_mat  = accept && kind == tmvm_pkg::KIND_MAT && row_ok && col_ok;
		cmd.store_vec  = accept && kind == tmvm_pkg::KIND_VEC && row_ok;
	end

	assign mac_row  = mac_row_q;
	assign mat_addr = mat_addr_q;
	assign vec_addr = vec_addr_q;
	assign emit_idx = emit_idx_q;

endmodule

`default_nettype wire

### design/tmvm_dp.sv
// ----------------------------------------------------------------------------
// tmvm_dp
// Matrix and vector stores, the multiply-accumulate pipeline, the result
// buffer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmvm_dp #(
	parameter int MAX_N     = tmvm_pkg::DEF_MAX_N,
	parameter int FRAC_BITS = tmvm_pkg::DEF_FRAC_BITS,
	parameter int IW        = 4,
	parameter int MW        = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tmvm_pkg::cmd_t                cmd,
	input  wire logic [IW-1:0]                 mac_row,
	input  wire logic [MW-1:0]                 mat_addr,
	input  wire logic [IW-1:0]                 vec_addr,
	input  wire logic [IW-1:0]                 emit_idx,
	input  wire logic [tmvm_pkg::ROW_W-1:0]    row,
	input  wire logic [tmvm_pkg::ROW_W-1:0]    col,
	input  wire logic [tmvm_pkg::VALUE_W-1:0]  value,
	output tmvm_pkg::status_t                  st,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [tmvm_pkg::IDX_W-1:0]         out_index,
	output logic [tmvm_pkg::VALUE_W-1:0]       out_result,
	output logic                               out_sat,
	output logic                               out_last
);

	localparam int VW    = tmvm_pkg::VALUE_W;
	localparam int PW    = 2 * VW + 1;
	localparam int AW    = PW + $clog2(MAX_N + 1);
	localparam int DEPTH = MAX_N * MAX_N;
	localparam logic signed [VW:0] ONE_Q = (VW + 1)'(1) <<< FRAC_BITS;

	logic [VW-1:0]          mat_mem [DEPTH];
	logic [VW-1:0]          vec_mem [MAX_N];
	logic [VW:0]            rbuf    [MAX_N];

	// stage 1: operand reads
	logic                   valid_s1, first_s1, last_s1, inside_s1, unit_s1;
	logic [IW-1:0]          idx_s1;
	logic [VW-1:0]          mat_s1;
	logic signed [VW-1:0]   vec_s1;
	// stage 2: product
	logic                   valid_s2, first_s2, last_s2;
	logic [IW-1:0]          idx_s2;
	logic signed [PW-1:0]   prod_s2;
	// stage 3: accumulate
	logic                   fin_s3;
	logic [IW-1:0]          idx_s3;
	logic signed [AW-1:0]   acc_q;

	logic signed [VW:0]     a_op;
	logic signed [PW-1:0]   prod_c;
	logic signed [AW-1:0]   shifted;
	logic                   fits, sat_c;
	logic [VW-1:0]          res_c;
	logic [MW-1:0]          st_addr;

	// emission
	logic                   pend_s1, plast_s1;
	logic [IW-1:0]          pidx_s1;
	logic [VW:0]            rd_q;
	logic                   out_valid_q, out_sat_q, out_last_q;
	logic [IW-1:0]          out_idx_q;
	logic [VW-1:0]          out_res_q;

	assign st_addr = MW'(row) * MW'(MAX_N) + MW'(col);

	always_ff @(posedge clk) begin
		if (cmd.store_mat)
			mat_mem[st_addr] <= value;
		if (cmd.mac_valid)
			mat_s1 <= mat_mem[mat_addr];
	end

	// vector store: loads, or write-back of results as they are emitted
	always_ff @(posedge clk) begin
		if (cmd.store_vec)
			vec_mem[IW'(row)] <= value;
		else if (pend_s1)
			vec_mem[pidx_s1] <= rd_q[VW-1:0];
		if (cmd.mac_valid)
			vec_s1 <= vec_mem[vec_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fin_s3   <= 1'b0;
		end else begin
			valid_s1 <= cmd.mac_valid;
			valid_s2 <= valid_s1;
			fin_s3   <= valid_s2 && last_s2;
		end
	end

	assign a_op   = unit_s1 ? ONE_Q : {mat_s1[VW-1], mat_s1};
	assign prod_c = PW'(a_op) * PW'(vec_s1);

	always_ff @(posedge clk) begin
		first_s1  <= cmd.mac_first;
		last_s1   <= cmd.mac_last;
		inside_s1 <= cmd.mac_inside;
		unit_s1   <= cmd.mac_unit;
		idx_s1    <= mac_row;
		first_s2  <= first_s1;
		last_s2   <= last_s1;
		idx_s2    <= idx_s1;
		prod_s2   <= inside_s1 ? prod_c : '0;
		idx_s3    <= idx_s2;
		if (valid_s2)
			acc_q <= (first_s2 ? AW'(0) : acc_q) + AW'(prod_s2);
	end

	// floor shift, then clip to 32 bits
	assign shifted = acc_q >>> FRAC_BITS;
	assign fits    = (&shifted[AW-1:VW-1]) || !(|shifted[AW-1:VW-1]);
	assign sat_c   = !fits;
	assign res_c   = fits ? shifted[VW-1:0] :
	                 (acc_q[AW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}});

	always_ff @(posedge clk) begin
		if (fin_s3)
			rbuf[idx_s3] <= {sat_c, res_c};
		if (cmd.emit_valid)
			rd_q <= rbuf[emit_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= cmd.emit_valid;
			if (pend_s1)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pidx_s1  <= emit_idx;
		plast_s1 <= cmd.emit_last;
		if (pend_s1) begin
			out_idx_q  <= pidx_s1;
			out_res_q  <= rd_q[VW-1:0];
			out_sat_q  <= rd_q[VW];
			out_last_q <= plast_s1;
		end
	end

	assign st.mac_busy = valid_s1 || valid_s2 || fin_s3;
	assign st.rd_pend  = pend_s1;
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_index  = tmvm_pkg::IDX_W'(out_idx_q);
	assign out_result = out_res_q;
	assign out_sat    = out_sat_q;
	assign out_last   = out_last_q;

	a_pend_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q)
		else $error("result read lands on a full output register");

	a_no_mac_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_valid |-> !(valid_s1 || valid_s2 || fin_s3 || cmd.mac_valid))
		else $error("emission overlaps the MAC pipeline");

	a_one_read_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_valid |=> !cmd.emit_valid)
		else $error("back-to-back result reads");

	a_store_when_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.store_mat || cmd.store_vec) |-> !(valid_s1 || valid_s2 || fin_s3 || pend_s1))
		else $error("store collides with compute or write-back");

endmodule

`default_nettype wire
